// ===== rtl/core/mrrb_pkg.sv =====
// package for the broadcast node pool: sizes, codes, payload structs and helpers
// no dependencies; imported by every module of the block but mrrb_ram
`timescale 1ns / 1ps
`default_nettype none

package mrrb_pkg;

    // sizes
    localparam int CHANNELS     = 4;
    localparam int RING_DEPTH   = 16;
    localparam int SPARE_NODES  = 4;
    localparam int READERS      = 8;
    localparam int NODES_PER_CH = RING_DEPTH + SPARE_NODES;
    localparam int NODE_TOTAL   = CHANNELS * NODES_PER_CH;
    localparam int RING_SLOTS   = CHANNELS * RING_DEPTH;

    // widths
    localparam int POS_W   = $clog2(RING_DEPTH);
    localparam int DEPTH_W = POS_W + 1;
    localparam int RING_AW = $clog2(RING_SLOTS);
    localparam int NODE_AW = 7;
    localparam int PTR_W   = $clog2(NODES_PER_CH);
    localparam int CNT_W   = $clog2(NODES_PER_CH + 1);
    localparam int CH_W    = 2;
    localparam int RD_W    = 3;
    localparam int LEN_W   = 16;
    localparam int UC_W    = 4;
    localparam int NCH_W   = 3;
    localparam int Q_DEPTH = 2;

    // operation codes
    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_CLOSE   = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_ALLOC   = 3'd3;
    localparam logic [2:0] OP_WNODE   = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;
    localparam logic [2:0] OP_RELEASE = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_DATA  = 3'd1;
    localparam logic [2:0] ST_LOST     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_BAD_CH   = 3'd4;
    localparam logic [2:0] ST_NOT_OPEN = 3'd5;
    localparam logic [2:0] ST_BAD_NODE = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_DEPTH    = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN  = 2'd2;

    typedef logic [NODE_AW-1:0] node_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [CH_W-1:0]  channel;
        logic [RD_W-1:0]  reader;
        node_t            node;
        logic [LEN_W-1:0] total_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             node_valid;
        node_t            node_id;
        logic [LEN_W-1:0] node_len;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        in_item_t item;
        logic     ch_ok;
        logic     rd_ok;
        logic     nd_ok;
    } cmd_t;

    // channel that owns a node id
    function automatic logic [CH_W-1:0] node_chan(input node_t id);
        logic [CH_W-1:0] c;
        c = '0;
        for (int i = 1; i < CHANNELS; i++)
        begin
            if (id >= NODE_AW'(i * NODES_PER_CH))
            begin
                c = CH_W'(i);
            end
        end
        return c;
    endfunction

    // address of a free list entry
    function automatic node_t fl_addr(input logic [CH_W-1:0] c, input ptr_t p);
        return NODE_AW'(NODE_AW'(c) * NODE_AW'(NODES_PER_CH)) + NODE_AW'(p);
    endfunction

    // address of a ring slot
    function automatic logic [RING_AW-1:0] ring_addr(input logic [CH_W-1:0] c,
                                                     input pos_t p);
        return RING_AW'(RING_AW'(c) * RING_AW'(RING_DEPTH)) + RING_AW'(p);
    endfunction

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(NODES_PER_CH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ring position advance with wrap at the active depth
    function automatic pos_t pos_inc(input pos_t p, input logic [DEPTH_W-1:0] depth);
        return (({1'b0, p} + 1'b1) == depth) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mrrb_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mrrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/mrrb_front.sv =====
// front end: takes request transfers and classifies channel, reader and node
// depends on mrrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrrb_front import mrrb_pkg::*; (
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire in_item_t           req,
    input  wire logic [NCH_W-1:0]   eff_ch,
    input  wire logic [DEPTH_W-1:0] eff_depth,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output cmd_t                    cmd
);

    logic [CH_W-1:0] nd_ch;
    node_t           nd_off;

    // handshake passes straight to the queue
    assign cmd_valid = req_valid;
    assign req_ready = cmd_ready;

    // node ownership and range
    assign nd_ch  = node_chan(req.node);
    assign nd_off = req.node - fl_addr(nd_ch, '0);

    always_comb
    begin
        cmd.item  = req;
        cmd.ch_ok = {1'b0, req.channel} < eff_ch;
        cmd.rd_ok = int'(req.reader) < READERS;
        cmd.nd_ok = (int'(req.node) < NODE_TOTAL)
                 && ({1'b0, nd_ch} < eff_ch)
                 && (nd_off < NODE_AW'(eff_depth) + NODE_AW'(SPARE_NODES));
    end

endmodule

`default_nettype wire

// ===== rtl/core/mrrb_queue.sv =====
// short command queue between front and back
// depends on mrrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrrb_queue import mrrb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_data
);

    localparam int QP_W = $clog2(Q_DEPTH);
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    cmd_t            entry_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_reg, wr_next;
    logic [QP_W-1:0] rd_reg, rd_next;
    logic [QC_W-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign push_ready = cnt_reg != QC_W'(Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill updates
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == QP_W'(Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mrrb_back.sv =====
// back end: sequencer over ring, use count, length and free list memories
// depends on mrrb_pkg and mrrb_ram
`timescale 1ns / 1ps
`default_nettype none

module mrrb_back import mrrb_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               reinit,
    input  wire logic [NCH_W-1:0]   eff_ch,
    input  wire logic [DEPTH_W-1:0] eff_depth,
    input  wire logic [LEN_W-1:0]   max_len,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire cmd_t               cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output out_item_t               rsp
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_NDCHK  = 4'd2;
    localparam logic [3:0] S_RING   = 4'd3;
    localparam logic [3:0] S_OLDUC  = 4'd4;
    localparam logic [3:0] S_SLOT   = 4'd5;
    localparam logic [3:0] S_POP    = 4'd6;
    localparam logic [3:0] S_REL    = 4'd7;
    localparam logic [3:0] S_RDRING = 4'd8;
    localparam logic [3:0] S_RDUC   = 4'd9;

    // control state
    logic [3:0]             state_reg, state_next;
    pos_t                   wp_reg [CHANNELS];
    pos_t                   wp_next [CHANNELS];
    logic [READERS-1:0]     rd_open_reg, rd_open_next;
    logic [CH_W-1:0]        rd_ch_reg [READERS];
    logic [CH_W-1:0]        rd_ch_next [READERS];
    pos_t                   rd_b_reg [READERS];
    pos_t                   rd_b_next [READERS];
    pos_t                   rd_e_reg [READERS];
    pos_t                   rd_e_next [READERS];
    ptr_t                   fl_head_reg [CHANNELS];
    ptr_t                   fl_head_next [CHANNELS];
    ptr_t                   fl_tail_reg [CHANNELS];
    ptr_t                   fl_tail_next [CHANNELS];
    cnt_t                   fl_cnt_reg [CHANNELS];
    cnt_t                   fl_cnt_next [CHANNELS];
    logic [RING_SLOTS-1:0]  ring_vld_reg, ring_vld_next;
    logic [NODE_TOTAL-1:0]  uc_vld_reg, uc_vld_next;
    logic [NODE_TOTAL-1:0]  fl_vld_reg, fl_vld_next;
    logic                   out_valid_reg, out_valid_next;

    // payload state
    cmd_t                   cmd_reg, cmd_next;
    logic [RING_AW-1:0]     slot_reg, slot_next;
    node_t                  id_reg, id_next;
    out_item_t              out_reg, out_next;
    logic                   ring_rv_reg, uc_rv_reg, fl_rv_reg;
    node_t                  fl_raddr_reg;

    // memory ports
    logic                   ring_we, uc_we, nl_we, fl_we;
    logic [RING_AW-1:0]     ring_waddr, ring_raddr;
    node_t                  ring_wdata, ring_rdata;
    node_t                  uc_waddr, uc_raddr, nl_waddr, nl_raddr, fl_waddr, fl_raddr;
    logic [UC_W-1:0]        uc_wdata, uc_rdata, uc_cur;
    logic [LEN_W-1:0]       nl_wdata, nl_rdata, clamp_len;
    node_t                  fl_wdata, fl_rdata, pop_id;

    // command fields
    logic [CH_W-1:0]        ch;
    logic [RD_W-1:0]        rdx;
    logic [CH_W-1:0]        rch;
    pos_t                   rb, re, rw;
    logic [CH_W-1:0]        drop_ch;
    cnt_t                   init_n;

    mrrb_ram #(.WIDTH(NODE_AW), .DEPTH(RING_SLOTS)) u_ring (
        .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
        .raddr(ring_raddr), .rdata(ring_rdata)
    );

    mrrb_ram #(.WIDTH(UC_W), .DEPTH(NODE_TOTAL)) u_count (
        .clk(clk), .we(uc_we), .waddr(uc_waddr), .wdata(uc_wdata),
        .raddr(uc_raddr), .rdata(uc_rdata)
    );

    mrrb_ram #(.WIDTH(LEN_W), .DEPTH(NODE_TOTAL)) u_len (
        .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
        .raddr(nl_raddr), .rdata(nl_rdata)
    );

    mrrb_ram #(.WIDTH(NODE_AW), .DEPTH(NODE_TOTAL)) u_free (
        .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );

    assign ch        = cmd_reg.item.channel;
    assign rdx       = cmd_reg.item.reader;
    assign rch       = rd_ch_reg[rdx];
    assign rb        = rd_b_reg[rdx];
    assign re        = rd_e_reg[rdx];
    assign rw        = wp_reg[rch];
    assign uc_cur    = uc_rv_reg ? uc_rdata : '0;
    assign pop_id    = fl_rv_reg ? fl_rdata : fl_raddr_reg;
    assign drop_ch   = node_chan(id_reg);
    assign clamp_len = (cmd_reg.item.total_length > max_len) ? max_len
                                                             : cmd_reg.item.total_length;
    assign init_n    = CNT_W'(eff_depth) + CNT_W'(SPARE_NODES);

    assign cmd_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // sequencer
    always_comb
    begin
        logic             done;
        logic [2:0]       st;
        logic             nv;
        node_t            nid;
        logic [LEN_W-1:0] nlen;
        logic             do_drop;

        done    = 1'b0;
        st      = ST_OK;
        nv      = 1'b0;
        nid     = '0;
        nlen    = '0;
        do_drop = 1'b0;

        state_next     = state_reg;
        wp_next        = wp_reg;
        rd_open_next   = rd_open_reg;
        rd_ch_next     = rd_ch_reg;
        rd_b_next      = rd_b_reg;
        rd_e_next      = rd_e_reg;
        fl_head_next   = fl_head_reg;
        fl_tail_next   = fl_tail_reg;
        fl_cnt_next    = fl_cnt_reg;
        ring_vld_next  = ring_vld_reg;
        uc_vld_next    = uc_vld_reg;
        fl_vld_next    = fl_vld_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        id_next        = id_reg;
        out_next       = out_reg;

        ring_we    = 1'b0;
        ring_waddr = slot_reg;
        ring_wdata = id_reg;
        ring_raddr = slot_reg;
        uc_we      = 1'b0;
        uc_waddr   = id_reg;
        uc_wdata   = '0;
        uc_raddr   = id_reg;
        nl_we      = 1'b0;
        nl_waddr   = pop_id;
        nl_wdata   = '0;
        nl_raddr   = id_reg;
        fl_we      = 1'b0;
        fl_waddr   = fl_addr(drop_ch, fl_tail_reg[drop_ch]);
        fl_wdata   = id_reg;
        fl_raddr   = fl_addr(ch, fl_head_reg[ch]);

        // result taken
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                slot_next = ring_addr(ch, wp_reg[ch]);
                case (cmd_reg.item.op)
                    OP_OPEN:
                    begin
                        done = 1'b1;
                        if (!cmd_reg.ch_ok)
                        begin
                            st = ST_BAD_CH;
                        end
                        else if (!cmd_reg.rd_ok)
                        begin
                            st = ST_NOT_OPEN;
                        end
                        else
                        begin
                            rd_open_next[rdx] = 1'b1;
                            rd_ch_next[rdx]   = ch;
                            rd_b_next[rdx]    = wp_reg[ch];
                            rd_e_next[rdx]    = wp_reg[ch];
                        end
                    end

                    OP_CLOSE:
                    begin
                        done = 1'b1;
                        if (!cmd_reg.rd_ok || !rd_open_reg[rdx])
                        begin
                            st = ST_NOT_OPEN;
                        end
                        else
                        begin
                            rd_open_next[rdx] = 1'b0;
                        end
                    end

                    OP_WRITE:
                    begin
                        if (!cmd_reg.ch_ok)
                        begin
                            done = 1'b1;
                            st   = ST_BAD_CH;
                        end
                        else
                        begin
                            ring_raddr = ring_addr(ch, wp_reg[ch]);
                            state_next = S_RING;
                        end
                    end

                    OP_WNODE:
                    begin
                        if (!cmd_reg.ch_ok)
                        begin
                            done = 1'b1;
                            st   = ST_BAD_CH;
                        end
                        else if (!cmd_reg.nd_ok)
                        begin
                            done = 1'b1;
                            st   = ST_BAD_NODE;
                        end
                        else
                        begin
                            uc_raddr   = cmd_reg.item.node;
                            state_next = S_NDCHK;
                        end
                    end

                    OP_ALLOC:
                    begin
                        if (!cmd_reg.ch_ok)
                        begin
                            done = 1'b1;
                            st   = ST_BAD_CH;
                        end
                        else if (fl_cnt_reg[ch] == '0)
                        begin
                            done = 1'b1;
                            st   = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end

                    OP_READ:
                    begin
                        if (!cmd_reg.rd_ok || !rd_open_reg[rdx])
                        begin
                            done = 1'b1;
                            st   = ST_NOT_OPEN;
                        end
                        else if (rb == re && re == rw)
                        begin
                            done = 1'b1;
                            st   = ST_NO_DATA;
                        end
                        else if ((rb <= re && re <= rw) || (re <= rw && rw <= rb)
                              || (rw <= rb && rb <= re))
                        begin
                            rd_e_next[rdx] = rw;
                            rd_b_next[rdx] = pos_inc(rb, eff_depth);
                            ring_raddr     = ring_addr(rch, rb);
                            state_next     = S_RDRING;
                        end
                        else
                        begin
                            done           = 1'b1;
                            st             = ST_LOST;
                            rd_e_next[rdx] = rw;
                            rd_b_next[rdx] = rw;
                        end
                    end

                    OP_RELEASE:
                    begin
                        if (!cmd_reg.nd_ok)
                        begin
                            done = 1'b1;
                            st   = ST_BAD_NODE;
                        end
                        else
                        begin
                            uc_raddr   = cmd_reg.item.node;
                            id_next    = cmd_reg.item.node;
                            state_next = S_REL;
                        end
                    end

                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end

            // write node: node must be allocated
            S_NDCHK:
            begin
                if (uc_cur == '0)
                begin
                    done = 1'b1;
                    st   = ST_BAD_NODE;
                end
                else
                begin
                    state_next = S_RING;
                end
            end

            // old slot contents
            S_RING:
            begin
                if (ring_rv_reg)
                begin
                    id_next    = ring_rdata;
                    uc_raddr   = ring_rdata;
                    state_next = S_OLDUC;
                end
                else
                begin
                    state_next = S_SLOT;
                end
            end

            S_OLDUC:
            begin
                do_drop    = 1'b1;
                state_next = S_SLOT;
            end

            // fill the slot
            S_SLOT:
            begin
                if (cmd_reg.item.op == OP_WNODE)
                begin
                    done                    = 1'b1;
                    ring_we                 = 1'b1;
                    ring_wdata              = cmd_reg.item.node;
                    ring_vld_next[slot_reg] = 1'b1;
                    wp_next[ch]             = pos_inc(wp_reg[ch], eff_depth);
                end
                else if (fl_cnt_reg[ch] == '0)
                begin
                    done                    = 1'b1;
                    st                      = ST_EMPTY;
                    ring_vld_next[slot_reg] = 1'b0;
                end
                else
                begin
                    state_next = S_POP;
                end
            end

            // take the head of the free list
            S_POP:
            begin
                done             = 1'b1;
                fl_head_next[ch] = ptr_inc(fl_head_reg[ch]);
                fl_cnt_next[ch]  = fl_cnt_reg[ch] - 1'b1;
                uc_we            = 1'b1;
                uc_waddr         = pop_id;
                uc_wdata         = UC_W'(1);
                nl_we            = 1'b1;
                if (cmd_reg.item.op == OP_WRITE)
                begin
                    nl_wdata                = clamp_len;
                    ring_we                 = 1'b1;
                    ring_wdata              = pop_id;
                    ring_vld_next[slot_reg] = 1'b1;
                    wp_next[ch]             = pos_inc(wp_reg[ch], eff_depth);
                end
                else
                begin
                    nv  = 1'b1;
                    nid = pop_id;
                end
            end

            S_REL:
            begin
                done = 1'b1;
                if (uc_cur == '0)
                begin
                    st = ST_BAD_NODE;
                end
                else
                begin
                    do_drop = 1'b1;
                end
            end

            // read slot contents
            S_RDRING:
            begin
                if (ring_rv_reg)
                begin
                    id_next    = ring_rdata;
                    uc_raddr   = ring_rdata;
                    nl_raddr   = ring_rdata;
                    state_next = S_RDUC;
                end
                else
                begin
                    done = 1'b1;
                    st   = ST_NO_DATA;
                end
            end

            S_RDUC:
            begin
                done = 1'b1;
                nv   = 1'b1;
                nid  = id_reg;
                nlen = nl_rdata;
                if (uc_cur != {UC_W{1'b1}})
                begin
                    uc_we    = 1'b1;
                    uc_wdata = uc_cur + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // drop one reference, last one returns the node to its free list
        if (do_drop && uc_cur != '0)
        begin
            uc_we    = 1'b1;
            uc_waddr = id_reg;
            uc_wdata = uc_cur - 1'b1;
            if (uc_cur == UC_W'(1) && fl_cnt_reg[drop_ch] < CNT_W'(NODES_PER_CH))
            begin
                fl_we                 = 1'b1;
                fl_tail_next[drop_ch] = ptr_inc(fl_tail_reg[drop_ch]);
                fl_cnt_next[drop_ch]  = fl_cnt_reg[drop_ch] + 1'b1;
            end
        end

        if (uc_we)
        begin
            uc_vld_next[uc_waddr] = 1'b1;
        end
        if (fl_we)
        begin
            fl_vld_next[fl_waddr] = 1'b1;
        end

        if (done)
        begin
            state_next          = S_IDLE;
            out_valid_next      = 1'b1;
            out_next.status     = st;
            out_next.node_valid = nv;
            out_next.node_id    = nv ? nid : '0;
            out_next.node_len   = nv ? nlen : '0;
        end

        // configuration change restarts all tables
        if (reinit)
        begin
            ring_vld_next = '0;
            uc_vld_next   = '0;
            fl_vld_next   = '0;
            rd_open_next  = '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_next[c]      = '0;
                fl_head_next[c] = '0;
                if (NCH_W'(c) < eff_ch)
                begin
                    fl_cnt_next[c]  = init_n;
                    fl_tail_next[c] = (init_n == CNT_W'(NODES_PER_CH)) ? '0
                                                                       : PTR_W'(init_n);
                end
                else
                begin
                    fl_cnt_next[c]  = '0;
                    fl_tail_next[c] = '0;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_open_reg   <= '0;
            ring_vld_reg  <= '0;
            uc_vld_reg    <= '0;
            fl_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c]      <= '0;
                fl_head_reg[c] <= '0;
                fl_tail_reg[c] <= '0;
                fl_cnt_reg[c]  <= CNT_W'(NODES_PER_CH);
            end
            for (int r = 0; r < READERS; r++)
            begin
                rd_ch_reg[r] <= '0;
                rd_b_reg[r]  <= '0;
                rd_e_reg[r]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_open_reg   <= rd_open_next;
            ring_vld_reg  <= ring_vld_next;
            uc_vld_reg    <= uc_vld_next;
            fl_vld_reg    <= fl_vld_next;
            out_valid_reg <= out_valid_next;
            wp_reg        <= wp_next;
            fl_head_reg   <= fl_head_next;
            fl_tail_reg   <= fl_tail_next;
            fl_cnt_reg    <= fl_cnt_next;
            rd_ch_reg     <= rd_ch_next;
            rd_b_reg      <= rd_b_next;
            rd_e_reg      <= rd_e_next;
        end
    end

    // payload registers and read side valid flags
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        id_reg       <= id_next;
        out_reg      <= out_next;
        ring_rv_reg  <= ring_vld_reg[ring_raddr];
        uc_rv_reg    <= uc_vld_reg[uc_raddr];
        fl_rv_reg    <= fl_vld_reg[fl_raddr];
        fl_raddr_reg <= fl_raddr;
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_reader_ring_buffer_pool_top.sv =====
// The back sequencer handles one command at a time, each memory step waiting on a registered
// read of ring, count or free list; the two-entry queue in front of it takes requests meanwhile.
// Reset: asynchronous, clears every table at once through valid bits; no clearing pass.
// A write to the channels, depth or maximum length register sets reinit_reg, which reinitializes all tables.
// top level: configuration registers, front, queue and back; depends on mrrb_pkg, mrrb_front, mrrb_queue, mrrb_back
`timescale 1ns / 1ps
`default_nettype none

module multi_reader_ring_buffer_pool_top import mrrb_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire in_item_t         req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output out_item_t             rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [LEN_W-1:0] cfg_data
);

    logic [NCH_W-1:0]   chn_reg;
    logic [DEPTH_W-1:0] dep_reg;
    logic [LEN_W-1:0]   max_len_reg;
    logic               reinit_reg;
    logic [NCH_W-1:0]   eff_ch;
    logic [DEPTH_W-1:0] eff_depth;
    logic               f_valid, f_ready, b_valid, b_ready;
    cmd_t               f_cmd, b_cmd;

    assign cfg_ready = 1'b1;

    // clamp configuration to the built sizes
    assign eff_ch = (chn_reg == '0) ? NCH_W'(1)
                  : (chn_reg > NCH_W'(CHANNELS)) ? NCH_W'(CHANNELS) : chn_reg;
    assign eff_depth = (dep_reg == '0) ? DEPTH_W'(1)
                     : (dep_reg > DEPTH_W'(RING_DEPTH)) ? DEPTH_W'(RING_DEPTH) : dep_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chn_reg     <= NCH_W'(CHANNELS);
            dep_reg     <= DEPTH_W'(RING_DEPTH);
            max_len_reg <= '1;
            reinit_reg  <= 1'b0;
        end
        else
        begin
            reinit_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CHANNELS:
                    begin
                        chn_reg    <= cfg_data[NCH_W-1:0];
                        reinit_reg <= 1'b1;
                    end
                    CFG_DEPTH:
                    begin
                        dep_reg    <= cfg_data[DEPTH_W-1:0];
                        reinit_reg <= 1'b1;
                    end
                    CFG_MAX_LEN:
                    begin
                        max_len_reg <= cfg_data;
                        reinit_reg  <= 1'b1;
                    end
                    default:
                    begin
                        reinit_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    mrrb_front u_front (
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .eff_ch(eff_ch),
        .eff_depth(eff_depth),
        .cmd_valid(f_valid),
        .cmd_ready(f_ready),
        .cmd(f_cmd)
    );

    mrrb_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_data(f_cmd),
        .pop_valid(b_valid),
        .pop_ready(b_ready),
        .pop_data(b_cmd)
    );

    mrrb_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .reinit(reinit_reg),
        .eff_ch(eff_ch),
        .eff_depth(eff_depth),
        .max_len(max_len_reg),
        .cmd_valid(b_valid),
        .cmd_ready(b_ready),
        .cmd(b_cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mrrb_checker.sv =====
// port level checks for the broadcast node pool, bound to the top level
// depends on mrrb_pkg and multi_reader_ring_buffer_pool_top
`timescale 1ns / 1ps
`default_nettype none

module mrrb_checker import mrrb_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire in_item_t         req,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire out_item_t        rsp
);

    // a stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // without a node the node fields read zero
    a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.node_valid |-> rsp.node_id == '0 && rsp.node_len == '0)
        else $error("node fields set without a node");

    // a node comes only with ok status and a real id
    a_node_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.node_valid |-> rsp.status == ST_OK
                                     && int'(rsp.node_id) < NODE_TOTAL)
        else $error("node returned with bad status or id");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result present out of reset");

endmodule

bind multi_reader_ring_buffer_pool_top mrrb_checker u_mrrb_checker (.*);

`default_nettype wire
